[hw/rtl/taylor_series_evaluator_unit_defines.svh]
// Assertion macros shared by the Taylor series evaluator RTL.
`ifndef TAYLOR_SERIES_EVALUATOR_UNIT_DEFINES_SVH
`define TAYLOR_SERIES_EVALUATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TSE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tse check failed");
`define TSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tse check failed");
`else
`define TSE_ASSERT_IMPL(lbl, ante, cons)
`define TSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/tse_pkg.sv]
// Package: types and constants of the Taylor series evaluator.
`timescale 1ns / 1ps
package tse_pkg;

    localparam int unsigned DEF_MAX_TERMS = 64;
    localparam int unsigned DEF_FRAC_BITS = 40;

    localparam int unsigned QW     = 48;   // fixed-point word
    localparam int unsigned CNT_W  = 7;    // term count
    localparam int unsigned TOL_W  = 47;
    localparam int unsigned COEF_W = 14;   // coefficient and denominator
    localparam int unsigned DIVD_W = 62;   // magnitude of product times coefficient
    localparam int unsigned HALF_W = 24;   // multiplier operand width

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [2:0] {
        FN_SIN    = 3'd0,
        FN_COS    = 3'd1,
        FN_ARCSIN = 3'd2,
        FN_ARCCOS = 3'd3,
        FN_SINH   = 3'd4,
        FN_COSH   = 3'd5,
        FN_EXP    = 3'd6,
        FN_UNUSED = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        REG_FUNC = 2'd0,
        REG_MODE = 2'd1,
        REG_MAXT = 2'd2,
        REG_TOL  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_X1 = 2'd0,
        PH_X2 = 2'd1,
        PH_C  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT,
        ST_NEXT,
        ST_MUL,
        ST_MRES,
        ST_COEF,
        ST_DIV,
        ST_FIN,
        ST_ADD
    } state_t;

endpackage

[hw/rtl/taylor_series_evaluator_unit.sv]
// Top level of the Taylor series evaluator: sequencer, shared multiplier, I/O.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: argument, reference_value
//  m_axis    out  m_axis_tvalid/tready    tdata: partial_sum, abs_error, terms_used
//                                         tlast: last_result
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Each term after the first (but the second arccos term, -x) takes three passes
// through the shared 24x24 multiplier (two for exp), a wait on the restoring
// divider and the sequencing steps.
// Reset clears the sequencer and the output valid flag and loads the configuration defaults; cfg is always ready.
// A stalled output holds the sequencer in its emit step.
`timescale 1ns / 1ps
`include "taylor_series_evaluator_unit_defines.svh"
module taylor_series_evaluator_unit
    import tse_pkg::*;
#(
    parameter int unsigned MAX_TERMS = DEF_MAX_TERMS,
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [95:0]       s_axis_tdata,   // argument[47:0], reference_value[95:48]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // partial_sum, abs_error, terms_used, pad
    output logic              m_axis_tlast,   // last_result
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [TOL_W-1:0]  cfg_data
);
    localparam logic [63:0] HP_RAW  = HALF_PI_Q62 >> (62 - FRAC_BITS);
    localparam logic [QW-1:0] HALF_PI =
        (HP_RAW > {16'b0, Q_MAX}) ? Q_MAX : HP_RAW[QW-1:0];
    localparam logic [QW-1:0] Q_ONE =
        (FRAC_BITS >= QW - 1) ? Q_MAX : QW'(64'd1 << FRAC_BITS);
    localparam logic [CNT_W-1:0] TERM_CAP = CNT_W'(MAX_TERMS);

    // configuration
    logic [2:0]       func_reg;
    logic             mode_reg;
    logic [CNT_W-1:0] maxt_reg;
    logic [TOL_W-1:0] tol_reg;

    state_t state_reg, state_next;

    logic [QW-1:0]    x_reg, ref_reg, term_reg, sum_reg;
    logic [CNT_W-1:0] k_reg;
    logic [2:0]       fs_reg;
    logic [QW-1:0]    err_reg;
    logic             last_reg, emit_reg;
    phase_t           phase_reg;
    logic [QW-1:0]    ma_reg, mb_reg;
    logic             mneg_reg;
    logic [2:0]       mstep_reg;
    logic [2*HALF_W-1:0] prod_reg;
    logic [6:0]       pshift_reg;
    logic [2*QW-1:0]  acc_reg;
    logic [QW-1:0]    p_reg;
    logic [COEF_W-1:0] c_reg, d_reg;
    logic             qneg_reg;

    logic             out_valid_reg, out_last_reg;
    logic [QW-1:0]    out_sum_reg, out_err_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic             div_start, div_done;
    logic [DIVD_W-1:0] div_q;

    logic             s_accept, out_free, do_emit;
    logic [CNT_W-1:0] limit;
    logic [2:0]       fs_eff;
    logic [QW:0]      diff_w;
    logic [QW-1:0]    err_w;
    logic             last_w;
    logic [CNT_W-1:0] k_inc;
    logic [2*QW-1:0]  qv;
    logic [QW-1:0]    mres;
    logic [QW-1:0]    fin;
    logic [QW:0]      sum_w;
    logic [QW-1:0]    sum_sat;
    logic [QW-1:0]    x_neg;
    logic [QW-1:0]    first;
    logic [HALF_W-1:0] pa, pb;
    logic [7:0]       a1, a2, a3, a4, a5;
    logic [15:0]      d_mul, c_mul;

    assign fs_eff = (func_reg == FN_UNUSED) ? FN_SIN : func_reg;
    assign limit  = (maxt_reg == '0) ? CNT_W'(1) :
                    (maxt_reg > TERM_CAP) ? TERM_CAP : maxt_reg;

    always_comb
    begin
        unique case (func_t'(fs_eff))
            FN_COS, FN_COSH, FN_EXP: first = Q_ONE;
            FN_ARCCOS:               first = HALF_PI;
            default:                 first = s_axis_tdata[QW-1:0];
        endcase
    end

    assign diff_w = {ref_reg[QW-1], ref_reg} - {sum_reg[QW-1], sum_reg};
    assign err_w  = diff_w[QW] ? QW'(-diff_w) : diff_w[QW-1:0];
    assign last_w = (k_reg >= limit) || (!mode_reg && ({1'b0, tol_reg} >= err_w));
    assign k_inc  = k_reg + 1'b1;
    assign x_neg  = (x_reg == Q_MIN) ? Q_MAX : (~x_reg + 1'b1);

    // truncated Q product with saturation
    assign qv   = acc_reg >> FRAC_BITS;
    assign mres = (|qv[2*QW-1:QW-1]) ? (mneg_reg ? Q_MIN : Q_MAX) :
                  (mneg_reg ? (~{1'b0, qv[QW-2:0]} + 1'b1) : {1'b0, qv[QW-2:0]});
    assign fin  = (|div_q[DIVD_W-1:QW-1]) ? (qneg_reg ? Q_MIN : Q_MAX) :
                  (qneg_reg ? (~{1'b0, div_q[QW-2:0]} + 1'b1) : {1'b0, div_q[QW-2:0]});

    assign sum_w   = {sum_reg[QW-1], sum_reg} + {term_reg[QW-1], term_reg};
    assign sum_sat = (sum_w[QW] != sum_w[QW-1]) ? (sum_w[QW] ? Q_MIN : Q_MAX)
                                                : sum_w[QW-1:0];

    assign pa = mstep_reg[0] ? ma_reg[QW-1:HALF_W] : ma_reg[HALF_W-1:0];
    assign pb = mstep_reg[1] ? mb_reg[QW-1:HALF_W] : mb_reg[HALF_W-1:0];

    // coefficient factors 2n-1 .. 2n-5
    assign a1 = {k_reg, 1'b0} - 8'd1;
    assign a2 = {k_reg, 1'b0} - 8'd2;
    assign a3 = {k_reg, 1'b0} - 8'd3;
    assign a4 = {k_reg, 1'b0} - 8'd4;
    assign a5 = {k_reg, 1'b0} - 8'd5;

    always_comb
    begin
        d_mul = 16'd1;
        c_mul = 16'd1;
        case (func_t'(fs_reg))
            FN_COS, FN_COSH: d_mul = a2 * a3;
            FN_ARCSIN:
            begin
                c_mul = a3 * a3;
                d_mul = a2 * a1;
            end
            FN_ARCCOS:
            begin
                c_mul = a5 * a5;
                d_mul = a4 * a3;
            end
            FN_EXP:  d_mul = {9'b0, k_reg - 1'b1};
            default: d_mul = a1 * a2;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_EVAL;
            ST_EVAL: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!emit_reg)
                    state_next = ST_NEXT;
                else if (out_free)
                    state_next = last_reg ? ST_IDLE : ST_NEXT;
            end
            ST_NEXT:
                state_next = (fs_reg == FN_ARCCOS && k_inc == CNT_W'(2)) ? ST_ADD : ST_MUL;
            ST_MUL:  if (mstep_reg == 3'd4) state_next = ST_MRES;
            ST_MRES:
            begin
                if (phase_reg == PH_C)
                    state_next = ST_DIV;
                else if (phase_reg == PH_X1 && fs_reg != FN_EXP)
                    state_next = ST_MUL;
                else
                    state_next = ST_COEF;
            end
            ST_COEF: state_next = ST_MUL;
            ST_DIV:  if (div_done) state_next = ST_FIN;
            ST_FIN:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_EVAL;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        do_emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EMIT: do_emit = emit_reg && out_free;
            ST_MRES: div_start = (phase_reg == PH_C);
            default: ;
        endcase
    end

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= FN_SIN;
            mode_reg      <= 1'b0;
            maxt_reg      <= CNT_W'(10);
            tol_reg       <= TOL_W'(1099512);
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            mstep_reg     <= '0;
            phase_reg     <= PH_X1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_FUNC: func_reg <= cfg_data[2:0];
                    REG_MODE: mode_reg <= cfg_data[0];
                    REG_MAXT: maxt_reg <= cfg_data[CNT_W-1:0];
                    REG_TOL:  tol_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (do_emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (s_accept)
                k_reg <= CNT_W'(1);
            else if (state_reg == ST_NEXT)
                k_reg <= k_inc;
            if (state_reg == ST_MUL)
                mstep_reg <= (mstep_reg == 3'd4) ? 3'd0 : mstep_reg + 1'b1;
            if (state_reg == ST_NEXT)
                phase_reg <= PH_X1;
            else if (state_reg == ST_MRES && phase_reg == PH_X1 && fs_reg != FN_EXP)
                phase_reg <= PH_X2;
            else if (state_reg == ST_COEF)
                phase_reg <= PH_C;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            x_reg    <= s_axis_tdata[QW-1:0];
            ref_reg  <= s_axis_tdata[2*QW-1:QW];
            fs_reg   <= fs_eff;
            term_reg <= first;
            sum_reg  <= first;
        end
        if (state_reg == ST_EVAL)
        begin
            err_reg  <= err_w;
            last_reg <= last_w;
            emit_reg <= mode_reg || last_w;
        end
        if (do_emit)
        begin
            out_sum_reg  <= sum_reg;
            out_err_reg  <= err_reg;
            out_cnt_reg  <= k_reg;
            out_last_reg <= last_reg;
        end
        if (state_reg == ST_NEXT)
        begin
            if (fs_reg == FN_ARCCOS && k_inc == CNT_W'(2))
                term_reg <= x_neg;
            ma_reg   <= term_reg[QW-1] ? (~term_reg + 1'b1) : term_reg;
            mb_reg   <= x_reg[QW-1] ? (~x_reg + 1'b1) : x_reg;
            mneg_reg <= term_reg[QW-1] ^ x_reg[QW-1];
        end
        if (state_reg == ST_MUL)
        begin
            // product registered, added to the accumulator on the next step
            if (mstep_reg != 3'd4)
            begin
                prod_reg   <= pa * pb;
                pshift_reg <= 7'(HALF_W) *
                              {5'b0, {1'b0, mstep_reg[0]} + {1'b0, mstep_reg[1]}};
            end
            if (mstep_reg == 3'd0)
                acc_reg <= '0;
            else
                acc_reg <= acc_reg + ({{(2*QW-2*HALF_W){1'b0}}, prod_reg} << pshift_reg);
        end
        if (state_reg == ST_MRES)
        begin
            if (phase_reg == PH_X1 && fs_reg != FN_EXP)
            begin
                ma_reg   <= mres[QW-1] ? (~mres + 1'b1) : mres;
                mneg_reg <= mres[QW-1] ^ x_reg[QW-1];
            end
            else if (phase_reg != PH_C)
                p_reg <= mres;
        end
        if (state_reg == ST_COEF)
        begin
            c_reg    <= c_mul[COEF_W-1:0];
            d_reg    <= (d_mul == 16'd0) ? COEF_W'(1) : d_mul[COEF_W-1:0];
            ma_reg   <= p_reg[QW-1] ? (~p_reg + 1'b1) : p_reg;
            mb_reg   <= {{(QW-COEF_W){1'b0}}, c_mul[COEF_W-1:0]};
            qneg_reg <= p_reg[QW-1] ^ (fs_reg == FN_SIN || fs_reg == FN_COS);
        end
        if (state_reg == ST_FIN)
            term_reg <= fin;
        if (state_reg == ST_ADD)
            sum_reg <= sum_sat;
    end

    tse_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg[DIVD_W-1:0]),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_cnt_reg, out_err_reg, out_sum_reg};

    `TSE_ASSERT_NEXT(a_first_term, s_accept, k_reg == CNT_W'(1))
    `TSE_ASSERT_IMPL(a_count_cap, state_reg != ST_IDLE, k_reg <= TERM_CAP && k_reg != '0)
    `TSE_ASSERT_IMPL(a_out_count, m_axis_tvalid, out_cnt_reg != '0 && out_cnt_reg <= TERM_CAP)
    `TSE_ASSERT_IMPL(a_div_idle, div_done, state_reg == ST_DIV)
endmodule

[hw/rtl/tse_divider.sv]
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module tse_divider
    import tse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [COEF_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);
    localparam int unsigned IW = $clog2(DIVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [IW-1:0]     cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [COEF_W-1:0] rem_reg;
    logic [COEF_W-1:0] dsr_reg;
    logic [COEF_W:0]   trial;
    logic [COEF_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == IW'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // keep the remainder below the divisor
            if (!diff[COEF_W])
            begin
                rem_reg <= diff[COEF_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[COEF_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[verif/taylor_series_evaluator_unit_tb.sv]
// Testbench for the Taylor series evaluator: stream stimulus, predictor and scoreboard.
`timescale 1ns / 1ps
module taylor_series_evaluator_unit_tb;
    import tse_pkg::*;

    typedef struct {
        longint     sum;
        bit [47:0]  err;
        bit [6:0]   terms;
        bit         last;
    } series_result_t;

    class series_scoreboard;
        bit [2:0]        fn_sel;
        bit              table_mode;
        bit [6:0]        term_limit;
        bit [46:0]       tol;
        series_result_t  pending_results[$];
        int              mismatches;

        function new();
            fn_sel = FN_SIN;
            table_mode = 1'b0;
            term_limit = 7'd10;
            tol = 47'd1099512;
            mismatches = 0;
        endfunction

        function void write_reg(reg_idx_t idx, bit [46:0] val);
            case (idx)
                REG_FUNC: fn_sel = val[2:0];
                REG_MODE: table_mode = val[0];
                REG_MAXT: term_limit = val[6:0];
                REG_TOL:  tol = val;
                default: ;
            endcase
        endfunction

        function longint sat48(longint v);
            if (v > longint'(Q_MAX)) return longint'(Q_MAX);
            if (v < -(longint'(1) <<< 47)) return -(longint'(1) <<< 47);
            return v;
        endfunction

        function longint qmul(longint a, longint b);
            bit         neg;
            bit [127:0] prod;
            bit [127:0] q;
            longint     r;
            neg = (a < 0) != (b < 0);
            prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
            q = prod >> 40;
            if (q > (128'd1 << 48))
                q = 128'd1 << 48;
            r = longint'(q[63:0]);
            return sat48(neg ? -r : r);
        endfunction

        function int eff_limit();
            if (term_limit < 1) return 1;
            if (term_limit > 64) return 64;
            return int'(term_limit);
        endfunction

        function longint first_term(func_t fs, longint x);
            case (fs)
                FN_COS, FN_COSH, FN_EXP: return longint'(1) <<< 40;
                FN_ARCCOS:               return sat48(longint'(HALF_PI_Q62 >> 22));
                default:                 return x;
            endcase
        endfunction

        function longint next_term(func_t fs, longint n, longint t, longint x);
            longint p, c, d, q;
            bit     neg;
            c = 1;
            neg = 0;
            if (fs == FN_EXP) begin
                p = qmul(t, x);
                d = n - 1;
            end
            else begin
                if (fs == FN_ARCCOS && n == 2)
                    return sat48(-x);
                p = qmul(qmul(t, x), x);
                case (fs)
                    FN_COS: begin neg = 1; d = (2*n-2)*(2*n-3); end
                    FN_ARCSIN: begin c = (2*n-3)*(2*n-3); d = (2*n-2)*(2*n-1); end
                    FN_ARCCOS: begin c = (2*n-5)*(2*n-5); d = (2*n-4)*(2*n-3); end
                    FN_SINH: d = (2*n-1)*(2*n-2);
                    FN_COSH: d = (2*n-2)*(2*n-3);
                    default: begin neg = 1; d = (2*n-1)*(2*n-2); end
                endcase
            end
            if (d < 1) d = 1;
            q = (p * c) / d;
            return sat48(neg ? -q : q);
        endfunction

        function func_t active_fn();
            return (fn_sel == FN_UNUSED) ? FN_SIN : func_t'(fn_sel);
        endfunction

        // Partial sum after a given number of terms, used to aim references.
        function longint sum_after(longint x, int terms);
            longint t, s;
            t = first_term(active_fn(), x);
            s = t;
            for (int k = 2; k <= terms; k++) begin
                t = next_term(active_fn(), k, t, x);
                s = sat48(s + t);
            end
            return s;
        endfunction

        function void note_request(longint x, longint refv);
            func_t          fs;
            int             lim;
            longint         t, s, diff;
            bit [47:0]      e;
            bit             fin;
            series_result_t r;
            fs = active_fn();
            lim = eff_limit();
            t = first_term(fs, x);
            s = t;
            for (int k = 1; ; k++) begin
                if (k > 1) begin
                    t = next_term(fs, k, t, x);
                    s = sat48(s + t);
                end
                diff = refv - s;
                e = 48'(diff < 0 ? -diff : diff);
                fin = (k >= lim) || (!table_mode && e <= {1'b0, tol});
                if (table_mode || fin) begin
                    r.sum = s;
                    r.err = e;
                    r.terms = 7'(k);
                    r.last = fin;
                    pending_results.push_back(r);
                end
                if (fin) break;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(bit [47:0] sum, bit [47:0] err, bit [6:0] terms, bit last);
            series_result_t r;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result sum=%h terms=%0d", sum, terms));
                return;
            end
            r = pending_results.pop_front();
            if (sum !== r.sum[47:0])
                report($sformatf("partial_sum %h, want %h", sum, r.sum[47:0]));
            if (err !== r.err)
                report($sformatf("abs_error %h, want %h", err, r.err));
            if (terms !== r.terms)
                report($sformatf("terms_used %0d, want %0d", terms, r.terms));
            if (last !== r.last)
                report($sformatf("last_result %0d, want %0d", last, r.last));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [95:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [103:0]      m_axis_tdata;
    logic              m_axis_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [TOL_W-1:0]  cfg_data;

    series_scoreboard  sb;
    bit                quiet;
    bit                hold_req;

    taylor_series_evaluator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #80_000_000;
        $display("status: fail");
        $finish;
    end

    // Check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[47:0], m_axis_tdata[95:48], m_axis_tdata[102:96],
                            m_axis_tlast);
    end

    // Result side: random stalls, one long hold on request.
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Valid stays high; the caller drops it after the last write.
    task automatic write_reg(reg_idx_t idx, bit [46:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Hold until the block has drained, then write a full setting.
    task automatic set_mode(bit [2:0] fs, bit tbl, bit [6:0] lim, bit [46:0] tol);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        write_reg(REG_FUNC, 47'(fs));
        write_reg(REG_MODE, 47'(tbl));
        write_reg(REG_MAXT, 47'(lim));
        write_reg(REG_TOL, tol);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(logic [47:0] x, logic [47:0] refv);
        longint xs, rs;
        xs = $signed(x);
        rs = $signed(refv);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {refv, x};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(xs, rs);
    endtask

    function automatic logic [47:0] rand_word();
        return {16'($urandom), $urandom};
    endfunction

    // Argument within about +-2, where the series settle.
    function automatic logic [47:0] rand_arg();
        logic [41:0] r;
        r = {10'($urandom), $urandom};
        return {{6{r[41]}}, r};
    endfunction

    localparam logic [47:0] ONE_Q  = 48'h0100_0000_0000;
    localparam logic [47:0] HALF_Q = 48'h0080_0000_0000;

    initial
    begin
        logic [47:0] x, rv;
        bit [6:0]    lim;
        bit [46:0]   tol;
        int          pick;
        sb = new();
        quiet = 0;
        hold_req = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FUNC;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each function code, including the unused one, in table mode.
        for (int f = 0; f < 8; f++) begin
            set_mode(3'(f), 1'b1, 7'd3, 47'd1099512);
            send_request(HALF_Q, 48'h0);
            send_request((f % 2) ? Q_MAX : Q_MIN, (f % 2) ? Q_MIN : Q_MAX);
        end
        // Term limit zero, exact tolerance.
        set_mode(FN_SIN, 1'b0, 7'd0, 47'd0);
        send_request(ONE_Q, 48'h0);
        send_request(48'h0, 48'h0);
        // Term limit above the maximum, widest tolerance, saturating arguments.
        set_mode(FN_EXP, 1'b1, 7'd127, {47{1'b1}});
        send_request(Q_MAX, 48'h0);
        set_mode(FN_COSH, 1'b0, 7'd64, 47'd0);
        send_request(Q_MIN, Q_MAX);
        send_request(-ONE_Q, ONE_Q);

        // Random phases; the last one runs without idling.
        for (int ph = 0; ph < 11; ph++) begin
            pick = $urandom_range(0, 9);
            lim = (pick == 0) ? 7'($urandom_range(64, 127)) :
                  (pick == 1) ? 7'd0 : 7'($urandom_range(1, 14));
            pick = $urandom_range(0, 3);
            tol = (pick == 0) ? 47'd0 : (pick == 1) ? {47{1'b1}} :
                  (pick == 2) ? 47'($urandom_range(0, 1 << 24)) : 47'(rand_word());
            set_mode(3'($urandom_range(0, 7)), 1'($urandom_range(0, 2) == 0), lim, tol);
            if (ph == 10) quiet = 1;
            for (int i = 0; i < 19; i++) begin
                if (ph == 4 && i == 3) hold_req = 1;
                x = ($urandom_range(0, 4) == 0) ? rand_word() : rand_arg();
                pick = $urandom_range(0, 3);
                if (pick < 2)
                    rv = 48'(sb.sum_after($signed(x), $urandom_range(1, sb.eff_limit()))
                             + $signed($urandom_range(0, 2000)) - 1000);
                else if (pick == 2)
                    rv = rand_word();
                else
                    rv = '0;
                send_request(x, rv);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
